// ----- sv/bsm_pkg.sv -----
`default_nettype none

package bsm_pkg;

   // program counter is wide enough for a branch target of 256
   localparam int PC_W = 9;

   localparam logic [1:0] ACT_LOAD    = 2'd0;
   localparam logic [1:0] ACT_EXEC    = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;

   localparam logic [2:0] ST_RUN   = 3'd0;
   localparam logic [2:0] ST_HALT  = 3'd1;
   localparam logic [2:0] ST_UNDER = 3'd2;
   localparam logic [2:0] ST_OVER  = 3'd3;
   localparam logic [2:0] ST_END   = 3'd4;

   localparam logic [7:0] OP_HALT  = 8'd0;
   localparam logic [7:0] OP_CONST = 8'd1;
   localparam logic [7:0] OP_DUP   = 8'd2;
   localparam logic [7:0] OP_DROP  = 8'd3;
   localparam logic [7:0] OP_READ  = 8'd4;
   localparam logic [7:0] OP_PRINT = 8'd5;
   localparam logic [7:0] OP_JMP   = 8'd6;
   localparam logic [7:0] OP_BNZ   = 8'd7;
   localparam logic [7:0] OP_LSS   = 8'd8;
   localparam logic [7:0] OP_ADD   = 8'd9;
   localparam logic [7:0] OP_SUB   = 8'd10;

   typedef struct packed {
      logic [1:0] action;
      logic [6:0] load_address;
      logic [7:0] load_data;
      logic [7:0] read_char;
   } req_type;

   typedef struct packed {
      logic       print_valid;
      logic [7:0] print_char;
      logic       read_taken;
      logic [2:0] status;
      logic [6:0] program_counter;
   } rsp_type;

endpackage

`default_nettype wire

// ----- sv/bsm_ram.sv -----
`default_nettype none

// byte RAM, one write port, two registered read ports, write-to-read bypass
module bsm_ram #(
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [7:0]               wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [7:0]               rd_data_a,
   output logic      [7:0]               rd_data_b
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_a_ff;
   logic [7:0] rd_b_ff;
   logic [7:0] wr_data_ff;
   logic       fwd_a_ff;
   logic       fwd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff    <= mem_ff[rd_addr_a];
      rd_b_ff    <= mem_ff[rd_addr_b];
      wr_data_ff <= wr_data;
      fwd_a_ff   <= wr_en && (wr_addr == rd_addr_a);
      fwd_b_ff   <= wr_en && (wr_addr == rd_addr_b);
   end

   assign rd_data_a = fwd_a_ff ? wr_data_ff : rd_a_ff;
   assign rd_data_b = fwd_b_ff ? wr_data_ff : rd_b_ff;

endmodule

`default_nettype wire

// ----- sv/bsm_exec.sv -----
`default_nettype none

// machine state and instruction execution
module bsm_exec
   import bsm_pkg::*;
#(
   parameter int PROG_DEPTH  = 128,
   parameter int STACK_DEPTH = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire req_type                        req,
   input  wire logic [7:0]                     op,
   input  wire logic [7:0]                     opnd,
   input  wire logic [7:0]                     top,
   input  wire logic [7:0]                     sec,
   output logic                                prog_we,
   output logic [$clog2(PROG_DEPTH)-1:0]       prog_wa,
   output logic [7:0]                          prog_wd,
   output logic [$clog2(PROG_DEPTH)-1:0]       prog_ra_a,
   output logic [$clog2(PROG_DEPTH)-1:0]       prog_ra_b,
   output logic                                stk_we,
   output logic [$clog2(STACK_DEPTH)-1:0]      stk_wa,
   output logic [7:0]                          stk_wd,
   output logic [$clog2(STACK_DEPTH)-1:0]      stk_ra_a,
   output logic [$clog2(STACK_DEPTH)-1:0]      stk_ra_b,
   output rsp_type                             rsp
);

   localparam int PAW = $clog2(PROG_DEPTH);
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int CW  = $clog2(STACK_DEPTH + 1);

   logic [PC_W-1:0] pc_ff, pc_in, pc_n;
   logic [CW-1:0]   cnt_ff, cnt_in, cnt_m2, cnt_in_m1, cnt_in_m2;
   logic [2:0]      st_ff, st_in;
   logic            moved, full, empty, lt2;
   logic            pv, rt;
   logic [7:0]      pch;
   logic [PC_W-1:0] la_ext;
   logic [PC_W-1:0] pc_ra_b;

   assign full   = (cnt_ff == CW'(STACK_DEPTH));
   assign empty  = (cnt_ff == '0);
   assign lt2    = (cnt_ff < CW'(2));
   assign cnt_m2 = cnt_ff - CW'(2);
   assign la_ext = {2'b00, req.load_address};

   always_comb begin
      pc_in   = pc_ff;
      cnt_in  = cnt_ff;
      st_in   = st_ff;
      pc_n    = pc_ff;
      moved   = 1'b0;
      prog_we = 1'b0;
      stk_we  = 1'b0;
      stk_wa  = cnt_ff[SAW-1:0];
      stk_wd  = opnd;
      pv      = 1'b0;
      pch     = 8'd0;
      rt      = 1'b0;
      if (accept) begin
         unique case (req.action)
            ACT_LOAD: begin
               prog_we = (la_ext < PC_W'(PROG_DEPTH));
            end
            ACT_EXEC: begin
               if (st_ff == ST_RUN) begin
                  moved = 1'b1;
                  unique case (op)
                     OP_HALT: begin
                        st_in = ST_HALT;
                        moved = 1'b0;
                     end
                     OP_CONST, OP_READ: begin
                        if (full) begin
                           st_in = ST_OVER;
                           moved = 1'b0;
                        end else begin
                           stk_we = 1'b1;
                           stk_wd = (op == OP_CONST) ? opnd : req.read_char;
                           rt     = (op == OP_READ);
                           cnt_in = cnt_ff + CW'(1);
                           pc_n   = pc_ff + ((op == OP_CONST) ? PC_W'(2) : PC_W'(1));
                        end
                     end
                     OP_DUP: begin
                        if (empty) begin
                           st_in = ST_UNDER;
                           moved = 1'b0;
                        end else if (full) begin
                           st_in = ST_OVER;
                           moved = 1'b0;
                        end else begin
                           stk_we = 1'b1;
                           stk_wd = top;
                           cnt_in = cnt_ff + CW'(1);
                           pc_n   = pc_ff + PC_W'(1);
                        end
                     end
                     OP_DROP, OP_PRINT, OP_JMP, OP_BNZ: begin
                        if (empty) begin
                           st_in = ST_UNDER;
                           moved = 1'b0;
                        end else begin
                           cnt_in = cnt_ff - CW'(1);
                           if (op == OP_PRINT) begin
                              pv  = 1'b1;
                              pch = top;
                           end
                           if (op == OP_JMP) begin
                              pc_n = {1'b0, top};
                           end else if (op == OP_BNZ) begin
                              pc_n = (top != 8'd0) ? ({1'b0, opnd} + PC_W'(1))
                                                   : (pc_ff + PC_W'(2));
                           end else begin
                              pc_n = pc_ff + PC_W'(1);
                           end
                        end
                     end
                     OP_LSS, OP_ADD, OP_SUB: begin
                        if (lt2) begin
                           st_in = ST_UNDER;
                           moved = 1'b0;
                        end else begin
                           stk_we = 1'b1;
                           stk_wa = cnt_m2[SAW-1:0];
                           if (op == OP_LSS) begin
                              stk_wd = {7'd0, sec < top};
                           end else if (op == OP_ADD) begin
                              stk_wd = sec + top;
                           end else begin
                              stk_wd = sec - top;
                           end
                           cnt_in = cnt_ff - CW'(1);
                           pc_n   = pc_ff + PC_W'(1);
                        end
                     end
                     default: begin
                        pc_n = pc_ff + PC_W'(1);
                     end
                  endcase
                  if (moved) begin
                     pc_in = pc_n;
                     if (pc_n >= PC_W'(PROG_DEPTH - 1)) begin
                        st_in = ST_END;
                     end
                  end
               end
            end
            ACT_RESTART: begin
               pc_in  = '0;
               cnt_in = '0;
               st_in  = ST_RUN;
            end
            default: begin
            end
         endcase
      end
      if (reset) begin
         pc_in   = '0;
         cnt_in  = '0;
         st_in   = ST_RUN;
         prog_we = 1'b0;
         stk_we  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= '0;
         cnt_ff <= '0;
         st_ff  <= ST_RUN;
      end else begin
         pc_ff  <= pc_in;
         cnt_ff <= cnt_in;
         st_ff  <= st_in;
      end
   end

   // reads are issued at the next state so the operands are ready next cycle
   assign pc_ra_b   = pc_in + PC_W'(1);
   assign prog_ra_a = pc_in[PAW-1:0];
   assign prog_ra_b = pc_ra_b[PAW-1:0];
   assign prog_wa   = la_ext[PAW-1:0];
   assign prog_wd   = req.load_data;
   assign cnt_in_m1 = cnt_in - CW'(1);
   assign cnt_in_m2 = cnt_in - CW'(2);
   assign stk_ra_a  = cnt_in_m1[SAW-1:0];
   assign stk_ra_b  = cnt_in_m2[SAW-1:0];

   assign rsp.print_valid     = pv;
   assign rsp.print_char      = pch;
   assign rsp.read_taken      = rt;
   assign rsp.status          = st_in;
   assign rsp.program_counter = pc_in[6:0];

endmodule

`default_nettype wire

// ----- sv/bsm_out_buf.sv -----
`default_nettype none

// output register plus skid stage
module bsm_out_buf
   import bsm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire rsp_type in_data,
   output logic         in_stall,
   output logic         out_valid,
   input  wire logic    out_stall,
   output rsp_type      out_data
);

   logic    main_v_ff, main_v_in;
   logic    skid_v_ff, skid_v_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    main_free;

   assign main_free = !main_v_ff || !out_stall;

   always_comb begin
      main_v_in = main_v_ff;
      main_in   = main_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (main_free) begin
         if (skid_v_ff) begin
            main_v_in = 1'b1;
            main_in   = skid_ff;
            skid_v_in = 1'b0;
         end else begin
            main_v_in = in_valid;
            main_in   = in_data;
         end
      end else if (in_valid) begin
         skid_v_in = 1'b1;
         skid_in   = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign in_stall  = skid_v_ff;
   assign out_valid = main_v_ff;
   assign out_data  = main_ff;

endmodule

`default_nettype wire

// ----- sv/byte_stack_machine_core.sv -----
`default_nettype none

// Byte stack machine core.
// Request channel (req_valid / req_stall / req_data): each request loads one
// program byte, executes one instruction, restarts at address zero, or does
// nothing. Every request gives exactly one response on rsp_valid / rsp_stall
// / rsp_data carrying the print byte, the read flag, the status and the pc.
// The response is registered in the output stage (skid stage if stalled).
// Throughput: one request per cycle while req_stall is low. Program bytes
// and stack entries are read at the next pc and stack depth as each request
// finishes, so the operands of the following instruction are ready after
// the registered RAM read; writes to an entry being read bypass in the RAM.
// Reset: pc, depth and status clear and the output stages empty; program and
// stack RAM contents are kept (undefined until written). No clearing pass.
// Stall: a response that is stalled holds; one more request is taken into a
// skid stage, then req_stall rises until the output drains.
module byte_stack_machine_core
   import bsm_pkg::*;
#(
   parameter int PROG_DEPTH  = 128,
   parameter int STACK_DEPTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int PAW = $clog2(PROG_DEPTH);
   localparam int SAW = $clog2(STACK_DEPTH);

   logic           accept;
   logic           prog_we, stk_we;
   logic [PAW-1:0] prog_wa, prog_ra_a, prog_ra_b;
   logic [SAW-1:0] stk_wa, stk_ra_a, stk_ra_b;
   logic [7:0]     prog_wd, stk_wd;
   logic [7:0]     op, opnd, top, sec;
   rsp_type        rsp_next;

   // request taken
   assign accept = req_valid && !req_stall;

   // program memory: port a opcode, port b inline operand
   bsm_ram #(.DEPTH(PROG_DEPTH)) u_prog (
      .clock     (clock),
      .wr_en     (prog_we),
      .wr_addr   (prog_wa),
      .wr_data   (prog_wd),
      .rd_addr_a (prog_ra_a),
      .rd_addr_b (prog_ra_b),
      .rd_data_a (op),
      .rd_data_b (opnd)
   );

   // data stack: port a top, port b entry below
   bsm_ram #(.DEPTH(STACK_DEPTH)) u_stack (
      .clock     (clock),
      .wr_en     (stk_we),
      .wr_addr   (stk_wa),
      .wr_data   (stk_wd),
      .rd_addr_a (stk_ra_a),
      .rd_addr_b (stk_ra_b),
      .rd_data_a (top),
      .rd_data_b (sec)
   );

   bsm_exec #(.PROG_DEPTH(PROG_DEPTH), .STACK_DEPTH(STACK_DEPTH)) u_exec (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .op        (op),
      .opnd      (opnd),
      .top       (top),
      .sec       (sec),
      .prog_we   (prog_we),
      .prog_wa   (prog_wa),
      .prog_wd   (prog_wd),
      .prog_ra_a (prog_ra_a),
      .prog_ra_b (prog_ra_b),
      .stk_we    (stk_we),
      .stk_wa    (stk_wa),
      .stk_wd    (stk_wd),
      .stk_ra_a  (stk_ra_a),
      .stk_ra_b  (stk_ra_b),
      .rsp       (rsp_next)
   );

   bsm_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (rsp_next),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- sv/bsm_checker.sv -----
`default_nettype none

module bsm_checker
   import bsm_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // reset empties both output stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output not empty after reset");

   // skid only fills behind a pending response
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stall without pending response");

   a_print_read_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.print_valid && rsp_data.read_taken))
      else $error("print and read in one response");

   // a print only comes from an instruction that completed
   a_print_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.print_valid |->
         (rsp_data.status == ST_RUN) || (rsp_data.status == ST_END))
      else $error("print with failed status");

endmodule

bind byte_stack_machine_core bsm_checker u_checker (.*);

`default_nettype wire

// ----- test/tb_byte_stack_machine_core.sv -----
module tb_byte_stack_machine_core;
   import bsm_pkg::*;

   localparam int PROG_DEPTH  = 128;
   localparam int STACK_DEPTH = 16;

   // the package names no code for a request that does nothing
   localparam logic [1:0] ACT_NONE = 2'd3;

   // preload (128) + directed part + random programs, at least 720 requests in all
   localparam int PLANNED_ITEMS  = 720;
   localparam int HOLD_CYCLES    = 40;
   localparam int WATCHDOG_LIMIT = 2000;

   // a queued request, tagged with the idling phase it belongs to and whether
   // the sender must wait for every outstanding response before offering it
   typedef struct packed {
      logic       drain;
      logic [1:0] phase;
      req_type    req;
   } queued_req;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   byte_stack_machine_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow machine: program memory, data stack, pc, depth and status as
   // the core should hold them after every accepted request.
   // ---------------------------------------------------------------------
   logic [7:0]  shadow_prog  [PROG_DEPTH];
   logic [7:0]  shadow_stack [STACK_DEPTH];
   int unsigned shadow_pc     = 0;
   int unsigned shadow_depth  = 0;
   logic [2:0]  shadow_status = ST_RUN;

   rsp_type     expected_rsp  [$];
   queued_req   request_queue [$];

   int          queued_count  = 0;
   bit          drain_next    = 1'b0;
   int          programs_made = 0;
   int          hold_at       = -1;
   int          hold_left     = 0;
   int          rsp_seen      = 0;
   int          mismatches    = 0;
   int          quiet_cycles  = 0;
   logic [1:0]  rate_phase    = 2'd0;

   // run tallies for the closing summary
   int          action_tally [4];
   int          stop_tally   [8];
   int          print_tally   = 0;
   int          read_tally    = 0;

   // Applies one request to the shadow machine and returns the response it
   // should produce. Stack checks come before any effect: a faulting
   // instruction only changes the status.
   function automatic rsp_type run_request(input req_type r);
      rsp_type     o;
      logic [7:0]  op, a, b;
      int unsigned next_pc, pops, pushes;
      o = '0;
      case (r.action)
         ACT_LOAD: shadow_prog[r.load_address] = r.load_data;
         ACT_RESTART: begin
            shadow_pc     = 0;
            shadow_depth  = 0;
            shadow_status = ST_RUN;
         end
         ACT_EXEC: if (shadow_status == ST_RUN) begin
            op      = shadow_prog[shadow_pc];
            next_pc = shadow_pc + 1;
            pops    = 0;
            pushes  = 0;
            case (op)
               OP_CONST, OP_READ:                  pushes = 1;
               OP_DUP:                             begin pops = 1; pushes = 2; end
               OP_DROP, OP_PRINT, OP_JMP, OP_BNZ:  pops = 1;
               OP_LSS, OP_ADD, OP_SUB:             begin pops = 2; pushes = 1; end
               default: ;
            endcase
            if (op == OP_HALT) begin
               shadow_status = ST_HALT;
            end else if (shadow_depth < pops) begin
               shadow_status = ST_UNDER;
            end else if (shadow_depth - pops + pushes > STACK_DEPTH) begin
               shadow_status = ST_OVER;
            end else begin
               case (op)
                  OP_CONST: begin
                     shadow_stack[shadow_depth] = shadow_prog[shadow_pc + 1];
                     shadow_depth++;
                     next_pc = shadow_pc + 2;
                  end
                  OP_DUP: begin
                     shadow_stack[shadow_depth] = shadow_stack[shadow_depth - 1];
                     shadow_depth++;
                  end
                  OP_DROP: shadow_depth--;
                  OP_READ: begin
                     shadow_stack[shadow_depth] = r.read_char;
                     shadow_depth++;
                     o.read_taken = 1'b1;
                  end
                  OP_PRINT: begin
                     shadow_depth--;
                     o.print_char  = shadow_stack[shadow_depth];
                     o.print_valid = 1'b1;
                  end
                  OP_JMP: begin
                     shadow_depth--;
                     next_pc = shadow_stack[shadow_depth];
                  end
                  OP_BNZ: begin
                     shadow_depth--;
                     // taken branch lands one past the operand, so 255 reaches 256
                     if (shadow_stack[shadow_depth] != 8'd0)
                        next_pc = int'(shadow_prog[shadow_pc + 1]) + 1;
                     else
                        next_pc = shadow_pc + 2;
                  end
                  OP_LSS, OP_ADD, OP_SUB: begin
                     a = shadow_stack[shadow_depth - 2];
                     b = shadow_stack[shadow_depth - 1];
                     if (op == OP_LSS)      a = (a < b) ? 8'd1 : 8'd0;
                     else if (op == OP_ADD) a = a + b;
                     else                   a = a - b;
                     shadow_stack[shadow_depth - 2] = a;
                     shadow_depth--;
                  end
                  default: ;   // undefined opcodes step over one byte
               endcase
               shadow_pc = next_pc;
               // the last program byte is never executed
               if (shadow_pc >= PROG_DEPTH - 1) shadow_status = ST_END;
            end
            if (shadow_status != ST_RUN) stop_tally[shadow_status]++;
         end
         default: ;
      endcase
      o.status          = shadow_status;
      o.program_counter = shadow_pc[6:0];
      return o;
   endfunction

   // idling rates per phase: receiver-heavy, then swapped to sender-heavy, then none
   function automatic int gap_pct(input bit sender, input logic [1:0] p);
      case (p)
         2'd0:    return sender ? 36 : 59;
         2'd1:    return sender ? 59 : 36;
         default: return 0;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("mismatch on response %0d: %s is %0h, predicted %0h",
               rsp_seen, what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus building
   // ---------------------------------------------------------------------
   task automatic send(input logic [1:0] act, input int addr, input int data, input int rd);
      queued_req q;
      int        ph;
      ph                  = queued_count * 3 / PLANNED_ITEMS;
      q.req.action        = act;
      q.req.load_address  = addr[6:0];
      q.req.load_data     = data[7:0];
      q.req.read_char     = rd[7:0];
      q.drain             = drain_next;
      q.phase             = (ph > 2) ? 2'd2 : 2'(ph);
      drain_next          = 1'b0;
      request_queue.push_back(q);
      queued_count++;
   endtask

   task automatic load(input int addr, input int data);
      send(ACT_LOAD, addr, data, $urandom_range(255));
   endtask

   // non-load request: address and data fields carry noise
   task automatic other(input logic [1:0] act);
      send(act, $urandom_range(127), $urandom_range(255), $urandom_range(255));
   endtask

   // A short random program, loaded and then stepped through. Mostly placed
   // at address zero; now and then placed high behind a computed jump so
   // the run falls off the end of memory.
   task automatic random_program();
      logic [7:0] body [$];
      int base, len, depth_est, push_pct, pick, steps, target;
      base      = 0;
      len       = $urandom_range(4, 22);
      depth_est = 0;
      push_pct  = $urandom_range(25, 85);
      if ($urandom_range(7) == 0) base = $urandom_range(100, 124);
      while (body.size() < len && base + body.size() < 126) begin
         pick   = $urandom_range(99);
         target = ($urandom_range(3) == 0) ? $urandom_range(126, 256)
                                           : base + $urandom_range(len);
         if (pick < 5) begin
            body.push_back(8'($urandom_range(11, 255)));
         end else if (pick < 5 + push_pct || (depth_est == 0 && pick < 95)) begin
            case ($urandom_range(2))
               0: begin
                  body.push_back(OP_CONST);
                  body.push_back(8'($urandom_range(255)));
               end
               1:       body.push_back(OP_READ);
               default: body.push_back(depth_est > 0 ? OP_DUP : OP_READ);
            endcase
            depth_est++;
         end else begin
            case ($urandom_range(6))
               0: body.push_back(OP_DROP);
               1: body.push_back(OP_PRINT);
               2: body.push_back(OP_LSS);
               3: body.push_back(OP_ADD);
               4: body.push_back(OP_SUB);
               5: begin
                  body.push_back(OP_CONST);
                  body.push_back(8'(target));
                  body.push_back(OP_JMP);
               end
               default: begin
                  body.push_back(OP_BNZ);
                  body.push_back(8'(target - 1));
               end
            endcase
            depth_est--;
            if (depth_est < 0) depth_est = 0;
         end
      end
      if ($urandom_range(2) == 0) body.push_back(OP_HALT);

      if (programs_made == 0 || $urandom_range(9) == 0) drain_next = 1'b1;
      programs_made++;
      if (base != 0) begin
         load(0, OP_CONST);
         load(1, base);
         load(2, OP_JMP);
      end
      for (int i = 0; i < body.size() && base + i < PROG_DEPTH; i++)
         load(base + i, body[i]);
      if ($urandom_range(5) == 0) other(ACT_NONE);
      other(ACT_RESTART);

      // run past the likely stop so a stopped machine gets steps too
      steps = $urandom_range(len / 2 + 2, 2 * len + 8);
      repeat (steps) begin
         pick = $urandom_range(99);
         if (pick < 5)      load($urandom_range(127), $urandom_range(255));
         else if (pick < 8) other(ACT_NONE);
         else if (pick < 9) other(ACT_RESTART);
         else               other(ACT_EXEC);
      end
   endtask

   initial begin
      logic [7:0] demo [$];

      // Program memory is undefined until written, so every address gets a
      // byte before the first step. The low bytes hold a walk through the
      // arithmetic: 0xFF + 1 wraps to 0, 0 - 0x80 gives 0x80, 0x80 < 0x0C is
      // false, the branch falls through and a jump to 127 runs off the end.
      demo = '{OP_READ, OP_CONST, 8'h01, OP_ADD, OP_DUP, OP_PRINT,
               OP_CONST, 8'h80, OP_SUB, OP_CONST, 8'h0C, OP_LSS,
               OP_BNZ, 8'hFF, OP_CONST, 8'h7F, OP_JMP};
      for (int i = 0; i < PROG_DEPTH; i++)
         load(i, (i < demo.size()) ? int'(demo[i]) : $urandom_range(255));

      // directed part
      send(ACT_EXEC, $urandom_range(127), $urandom_range(255), 8'hFF);
      repeat (13) other(ACT_EXEC);      // the last two find the machine stopped
      other(ACT_NONE);
      other(ACT_RESTART);
      load(0, OP_DROP);                 // pop from an empty stack
      other(ACT_EXEC);
      other(ACT_EXEC);
      other(ACT_RESTART);
      load(0, OP_HALT);                 // halt keeps pc on the instruction
      other(ACT_EXEC);
      other(ACT_RESTART);

      // random part
      while (queued_count < PLANNED_ITEMS) random_program();

      // long receiver hold-off, placed within the phase with no idling
      hold_at = queued_count - 120;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Run covered %0d requests: %0d loads, %0d steps, %0d restarts, %0d idle;",
               rsp_seen, action_tally[ACT_LOAD], action_tally[ACT_EXEC],
               action_tally[ACT_RESTART], action_tally[ACT_NONE]);
      $display("%0d printed, %0d read; stops: %0d halt, %0d under, %0d over, %0d off end",
               print_tally, read_tally, stop_tally[ST_HALT], stop_tally[ST_UNDER],
               stop_tally[ST_OVER], stop_tally[ST_END]);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request driver. Prediction happens as the request is taken; one
   // request gives exactly one response, so the store of predictions stays
   // in request order.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      logic      taken, busy;
      rsp_type   predicted;
      queued_req nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         taken = req_valid && !req_stall;
         if (taken) begin
            predicted = run_request(req_data);
            expected_rsp.push_back(predicted);
            action_tally[req_data.action]++;
            print_tally += predicted.print_valid;
            read_tally  += predicted.read_taken;
         end
         // a request on offer but stalled stays exactly as it is
         busy = req_valid && !taken;
         if (!busy) begin
            if (request_queue.size() != 0
                && !(request_queue[0].drain && expected_rsp.size() != 0)
                && $urandom_range(99) >= gap_pct(1'b1, request_queue[0].phase)) begin
               nxt = request_queue.pop_front();
               req_valid  <= 1'b1;
               req_data   <= nxt.req;
               rate_phase <= nxt.phase;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: field-by-field check against the oldest prediction,
   // plus random stalls and one long hold-off that backs the core up.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : response_monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (expected_rsp.size() == 0) begin
               report_mismatch("response with no request pending", rsp_data, '0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.print_valid !== want.print_valid)
                  report_mismatch("print_valid", rsp_data.print_valid, want.print_valid);
               if (rsp_data.print_char !== want.print_char)
                  report_mismatch("print_char", rsp_data.print_char, want.print_char);
               if (rsp_data.read_taken !== want.read_taken)
                  report_mismatch("read_taken", rsp_data.read_taken, want.read_taken);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.program_counter !== want.program_counter)
                  report_mismatch("program_counter", rsp_data.program_counter,
                                  want.program_counter);
            end
            if (rsp_seen == hold_at) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < gap_pct(1'b0, rate_phase));
         end
      end
   end

   // watchdog: too long with nothing moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("stalled for %0d cycles with %0d requests queued, %0d responses due",
                  WATCHDOG_LIMIT, request_queue.size(), expected_rsp.size());
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ----- sim.f -----
sv/bsm_pkg.sv
sv/bsm_ram.sv
sv/bsm_exec.sv
sv/bsm_out_buf.sv
sv/byte_stack_machine_core.sv
sv/bsm_checker.sv
test/tb_byte_stack_machine_core.sv
